FILE: rtl/core/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// clocked assertion helpers used by the hbp_packer module of the bit packer
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property, disabled while reset is held
`define HBP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// implication checked in the next cycle, disabled while reset is held
`define HBP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/hbp_pkg.sv
// ---------------------------------------------------------------------------
// hbp_pkg
// types, widths and helpers for the huffman bit packer
// ---------------------------------------------------------------------------
package hbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int REQ_W        = 2;
    localparam int SYM_W        = 8;
    localparam int CODE_W       = 32;
    localparam int LEN_W        = 6;
    localparam int BYTE_W       = 8;
    localparam int PEND_W       = 7;
    localparam int PCNT_W       = 3;
    localparam int ACC_W        = PEND_W + MAX_CODE_LEN;
    localparam int TOTAL_W      = 6;
    localparam int MAX_BYTES    = 4;
    localparam int ECNT_W       = 3;
    localparam int QUEUE_W      = MAX_BYTES * BYTE_W;
    localparam int TABLE_DEPTH  = 1 << SYM_W;

    typedef enum logic [REQ_W-1:0] {
        REQ_LOAD   = 2'd0,
        REQ_ENCODE = 2'd1,
        REQ_FLUSH  = 2'd2
    } t_req_type;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } t_code_entry;

    typedef struct packed {
        logic        wr_en;
        logic        rd_en;
        logic [SYM_W-1:0] addr;
        t_code_entry wr_entry;
    } t_mem_req;

    function automatic logic [LEN_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        return (len > LEN_W'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN) : len;
    endfunction

    function automatic logic [CODE_W-1:0] mask_code(input logic [CODE_W-1:0] code,
                                                    input logic [LEN_W-1:0]  len);
        logic [CODE_W:0] m;
        m = ({{CODE_W{1'b0}}, 1'b1} << len) - 1'b1;
        return code & m[CODE_W-1:0];
    endfunction

endpackage

FILE: rtl/core/hbp_req_if.sv
// ---------------------------------------------------------------------------
// hbp_req_if
// request channel: load, encode or flush items
// ---------------------------------------------------------------------------
interface hbp_req_if;
    logic                          valid;
    logic                          ready;
    logic [hbp_pkg::REQ_W-1:0]     req_type;
    logic [hbp_pkg::SYM_W-1:0]     symbol;
    logic [hbp_pkg::CODE_W-1:0]    code_bits;
    logic [hbp_pkg::LEN_W-1:0]     code_len;

    modport source (output valid, req_type, symbol, code_bits, code_len, input ready);
    modport sink   (input valid, req_type, symbol, code_bits, code_len, output ready);
endinterface

FILE: rtl/core/hbp_byte_if.sv
// ---------------------------------------------------------------------------
// hbp_byte_if
// packed byte channel with end-of-item marker
// ---------------------------------------------------------------------------
interface hbp_byte_if;
    logic                          valid;
    logic                          ready;
    logic [hbp_pkg::BYTE_W-1:0]    out_byte;
    logic                          last;

    modport source (output valid, out_byte, last, input ready);
    modport sink   (input valid, out_byte, last, output ready);
endinterface

FILE: rtl/core/hbp_code_mem.sv
// ---------------------------------------------------------------------------
// hbp_code_mem
// 256-entry code table, one port, registered read, per-entry valid bits
// ---------------------------------------------------------------------------
module hbp_code_mem (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  hbp_pkg::t_mem_req    i_req,
    output hbp_pkg::t_code_entry o_entry
);
    import hbp_pkg::*;

    t_code_entry              mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   r_valid;
    t_code_entry              r_rd_data;
    logic                     r_rd_hit;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            mem[i_req.addr] <= i_req.wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= mem[i_req.addr];
        end
    end

    // entries never loaded read back as length zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_valid[i_req.addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_hit <= r_valid[i_req.addr];
            end
        end
    end

    assign o_entry = r_rd_hit ? r_rd_data : '0;

endmodule

FILE: rtl/core/hbp_packer.sv
// ---------------------------------------------------------------------------
// hbp_packer
// lookup stage, pending bit buffer and byte emitter
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module hbp_packer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [hbp_pkg::REQ_W-1:0]     i_req_type,
    input  hbp_pkg::t_code_entry          i_entry,
    output logic                          o_ready,
    hbp_byte_if.source                    o_byte
);
    import hbp_pkg::*;

    logic                 r_s1_valid;
    logic                 r_s1_flush;
    logic [PEND_W-1:0]    r_pend_bits;
    logic [PCNT_W-1:0]    r_pend_cnt;
    logic [QUEUE_W-1:0]   r_emit_q;
    logic [ECNT_W-1:0]    r_emit_cnt;

    logic [PEND_W-1:0]    n_pend_bits;
    logic [PCNT_W-1:0]    n_pend_cnt;
    logic [QUEUE_W-1:0]   n_emit_q;
    logic [ECNT_W-1:0]    n_emit_cnt;

    logic                 s1_take;
    logic                 s1_move;
    logic                 emit_free;
    logic                 emit_take;

    logic [ACC_W-1:0]     acc;
    logic [TOTAL_W-1:0]   total;
    logic [TOTAL_W-1:0]   align_shift;
    logic [ACC_W-1:0]     aligned;
    logic [PEND_W-1:0]    pend_mask;
    logic [BYTE_W-1:0]    flush_byte;

    assign s1_take   = i_accept && ((i_req_type == REQ_ENCODE) || (i_req_type == REQ_FLUSH));
    assign emit_take = (r_emit_cnt != '0) && o_byte.ready;
    assign emit_free = (r_emit_cnt == '0) || ((r_emit_cnt == ECNT_W'(1)) && o_byte.ready);
    assign s1_move   = r_s1_valid && emit_free;
    assign o_ready   = !r_s1_valid || emit_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_flush <= 1'b0;
        end else begin
            if (s1_take || s1_move) begin
                r_s1_valid <= s1_take;
            end
            if (s1_take) begin
                r_s1_flush <= (i_req_type == REQ_FLUSH);
            end
        end
    end

    // append code below pending bits, then left-align the whole bytes
    assign acc         = ({{MAX_CODE_LEN{1'b0}}, r_pend_bits} << i_entry.len)
                         | {{PEND_W{1'b0}}, i_entry.code};
    assign total       = TOTAL_W'(r_pend_cnt) + i_entry.len;
    assign align_shift = TOTAL_W'(ACC_W) - total;
    assign aligned     = acc << align_shift;
    assign pend_mask   = ~({PEND_W{1'b1}} << total[PCNT_W-1:0]);
    assign flush_byte  = {1'b0, r_pend_bits} << (4'd8 - {1'b0, r_pend_cnt});

    always_comb begin
        n_pend_bits = r_pend_bits;
        n_pend_cnt  = r_pend_cnt;
        n_emit_q    = r_emit_q;
        n_emit_cnt  = r_emit_cnt;
        if (s1_move) begin
            if (r_s1_flush) begin
                n_pend_bits = '0;
                n_pend_cnt  = '0;
                n_emit_q    = {flush_byte, {(BYTE_W-PCNT_W){1'b0}}, r_pend_cnt,
                               {(QUEUE_W-2*BYTE_W){1'b0}}};
                n_emit_cnt  = ECNT_W'(2);
            end else begin
                n_pend_bits = acc[PEND_W-1:0] & pend_mask;
                n_pend_cnt  = total[PCNT_W-1:0];
                n_emit_q    = aligned[ACC_W-1 -: QUEUE_W];
                n_emit_cnt  = total[TOTAL_W-1:PCNT_W];
            end
        end else if (emit_take) begin
            n_emit_q   = {r_emit_q[QUEUE_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
            n_emit_cnt = r_emit_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bits <= '0;
            r_pend_cnt  <= '0;
            r_emit_cnt  <= '0;
        end else begin
            r_pend_bits <= n_pend_bits;
            r_pend_cnt  <= n_pend_cnt;
            r_emit_cnt  <= n_emit_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_emit_q <= n_emit_q;
    end

    assign o_byte.valid    = (r_emit_cnt != '0);
    assign o_byte.out_byte = r_emit_q[QUEUE_W-1 -: BYTE_W];
    assign o_byte.last     = (r_emit_cnt == ECNT_W'(1));

    `HBP_ASSERT_NEXT(a_flush_clears, i_clk, i_rst_n, s1_move && r_s1_flush, (r_pend_cnt == '0) && (r_pend_bits == '0), "flush left pending bits")
    `HBP_ASSERT_NEXT(a_flush_two, i_clk, i_rst_n, s1_move && r_s1_flush, r_emit_cnt == ECNT_W'(2), "flush did not queue two bytes")
    `HBP_ASSERT(a_emit_bound, i_clk, i_rst_n, r_emit_cnt <= ECNT_W'(MAX_BYTES), "emitter holds too many bytes")
    `HBP_ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !emit_free, r_s1_valid, "lookup stage dropped an item")

endmodule

FILE: rtl/core/huffman_bit_packer.sv
// path: an encode or flush item goes through the lookup stage, then the emitter queue
// throughput: one item per cycle while each gives at most one byte and the byte side is
// ready; an item giving k bytes (up to 4 for encode, always 2 for flush) holds the single
// byte emitter until all k are taken; loads write the code table directly
// reset: synchronous, active low; clears the pending buffer, the emitter and the
// table valid bits at once, so no clearing pass is needed
// ---------------------------------------------------------------------------
// huffman_bit_packer
// table-driven huffman encoder for byte symbols, packing codes into bytes
// ---------------------------------------------------------------------------
module huffman_bit_packer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    hbp_req_if.sink     i_req,
    hbp_byte_if.source  o_byte
);
    import hbp_pkg::*;

    // request transfer and table access
    logic         req_accept;
    logic         packer_ready;
    t_mem_req     mem_req;
    t_code_entry  rd_entry;

    assign i_req.ready = packer_ready;
    assign req_accept  = i_req.valid && packer_ready;

    // a load writes the saturated length and the code cut to that length;
    // an encode reads its entry, which arrives with the item in the lookup stage
    always_comb begin
        mem_req.wr_en          = req_accept && (i_req.req_type == REQ_LOAD);
        mem_req.rd_en          = req_accept && (i_req.req_type == REQ_ENCODE);
        mem_req.addr           = i_req.symbol;
        mem_req.wr_entry.len   = sat_len(i_req.code_len);
        mem_req.wr_entry.code  = mask_code(i_req.code_bits, sat_len(i_req.code_len));
    end

    hbp_code_mem u_code_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mem_req),
        .o_entry (rd_entry)
    );

    // packing and byte output; unknown request types fall through untouched
    hbp_packer u_packer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (req_accept),
        .i_req_type (i_req.req_type),
        .i_entry    (rd_entry),
        .o_ready    (packer_ready),
        .o_byte     (o_byte)
    );

endmodule

FILE: tb/sv/huffman_bit_packer_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// huffman_bit_packer_test
// drives load, encode, flush and reserved requests into the bit packer with random
// gaps on both channels, predicts the packed bytes from its own copy of
// the code table and pending buffer or takes them from a directed row, and compares each byte transfer in order
// ---------------------------------------------------------------------------
module huffman_bit_packer_test;
    import hbp_pkg::*;

    // request type with no meaning to the block, expected to be dropped
    localparam logic [REQ_W-1:0] REQ_RESERVED = 2'd3;

    localparam int N_RANDOM_REQS = 245;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int DRAIN_CYCLES  = 16;
    localparam int MAX_REPORTS   = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] b;
        logic              last;
    } t_packed_byte;

    // one row of the directed table; typed rows carry their own expected bytes
    typedef struct {
        logic [REQ_W-1:0]  req;
        logic [SYM_W-1:0]  sym;
        logic [CODE_W-1:0] code;
        logic [LEN_W-1:0]  len;
        bit                typed;
        int                n;
        logic [31:0]       bytes;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    hbp_req_if  req_ch ();
    hbp_byte_if byte_ch ();

    huffman_bit_packer u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_byte  (byte_ch)
    );

    // predictor state: code table plus the bits still waiting for a full byte
    logic [CODE_W-1:0] tbl_code [TABLE_DEPTH];
    logic [LEN_W-1:0]  tbl_len  [TABLE_DEPTH];
    logic [PEND_W-1:0] carry_bits;
    logic [PCNT_W-1:0] carry_cnt;

    t_packed_byte byte_forecast [$];
    t_stim_row    stim_rows [$];
    int           alphabet [$];   // symbols loaded so far, to aim encodes at

    int  cycle_cnt    = 0;
    int  n_fail       = 0;
    int  n_bytes_seen = 0;
    int  n_load       = 0;
    int  n_encode     = 0;
    int  n_flush      = 0;
    int  n_reserved   = 0;
    bit  tx_calm      = 1'b0;
    bit  rx_calm      = 1'b0;

    // 2 ns clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    // idle length: mostly none or short, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // works out the bytes one request produces and moves the predictor state on;
    // byte k of the result sits in word[31-8k -: 8]
    task automatic predict_packing(input logic [REQ_W-1:0] req,
                                   input logic [SYM_W-1:0] sym,
                                   input logic [CODE_W-1:0] code,
                                   input logic [LEN_W-1:0] len,
                                   output int n, output logic [31:0] word);
        int unsigned l;
        int unsigned total;
        logic [63:0] acc;
        n    = 0;
        word = '0;
        case (req)
            REQ_LOAD: begin
                // saturate the length, then drop code bits above it
                l = (len > LEN_W'(MAX_CODE_LEN)) ? MAX_CODE_LEN : len;
                tbl_len[sym]  = LEN_W'(l);
                tbl_code[sym] = code & 32'((64'd1 << l) - 64'd1);
            end
            REQ_ENCODE: begin
                l     = tbl_len[sym];
                total = carry_cnt + l;
                acc   = (64'(carry_bits) << l) | 64'(tbl_code[sym]);
                while (total >= 8 && n < MAX_BYTES) begin
                    word[31 - 8*n -: 8] = 8'(acc >> (total - 8));
                    n++;
                    total -= 8;
                end
                carry_cnt  = PCNT_W'(total);
                carry_bits = PEND_W'(acc & ((64'd1 << total) - 64'd1));
            end
            REQ_FLUSH: begin
                // leftover bits padded with zeros, then the count of valid bits
                word[31:24] = 8'(16'(carry_bits) << (8 - carry_cnt));
                word[23:16] = 8'(carry_cnt);
                n           = 2;
                carry_bits  = '0;
                carry_cnt   = '0;
            end
            default: ;   // reserved type leaves everything as it was
        endcase
    endtask

    // presents one request from the falling edge on and holds it until the
    // transfer; a typed row queues its own bytes instead of the predicted ones
    task automatic send_req(input logic [REQ_W-1:0] req, input logic [SYM_W-1:0] sym,
                            input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len,
                            input bit typed, input int typed_n, input logic [31:0] typed_bytes);
        int           gap;
        int           n;
        logic [31:0]  word;
        t_packed_byte fc;
        gap = tx_calm ? 0 : idle_len();
        @(negedge i_clk);
        if (gap > 0) begin
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.req_type  = req;
        req_ch.symbol    = sym;
        req_ch.code_bits = code;
        req_ch.code_len  = len;
        req_ch.valid     = 1'b1;
        do @(posedge i_clk); while (!req_ch.ready);

        // transfer taken at this edge
        predict_packing(req, sym, code, len, n, word);
        if (typed) begin
            n    = typed_n;
            word = typed_bytes;
        end
        for (int k = 0; k < n; k++) begin
            fc.b          = word[31 - 8*k -: 8];
            fc.last       = (k == n - 1);
            byte_forecast = {byte_forecast, fc};
        end

        case (req)
            REQ_LOAD:   n_load++;
            REQ_ENCODE: n_encode++;
            REQ_FLUSH:  n_flush++;
            default:    n_reserved++;
        endcase
    endtask

    function automatic void add_row(logic [REQ_W-1:0] req, logic [SYM_W-1:0] sym,
                                    logic [CODE_W-1:0] code, logic [LEN_W-1:0] len,
                                    bit typed, int n, logic [31:0] bytes);
        t_stim_row row;
        row       = '{req, sym, code, len, typed, n, bytes};
        stim_rows = {stim_rows, row};
        if (req == REQ_LOAD) alphabet = {alphabet, int'(sym)};
    endfunction

    // byte side back-pressure, with quiet stretches where it never stalls
    initial begin
        int hold;
        int ticks;
        hold          = 0;
        ticks         = 0;
        byte_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            ticks++;
            if (ticks % 64 == 0) rx_calm = ($urandom_range(0, 3) == 0);
            if (hold > 0) begin
                byte_ch.ready = 1'b0;
                hold--;
            end else begin
                byte_ch.ready = 1'b1;
                if (!rx_calm && $urandom_range(0, 2) == 0) hold = idle_len();
            end
        end
    end

    // checks every byte transfer against the oldest prediction
    always @(posedge i_clk) begin
        t_packed_byte exp_b;
        if (i_rst_n && byte_ch.valid && byte_ch.ready) begin
            n_bytes_seen++;
            if (byte_forecast.size() == 0) begin
                n_fail++;
                if (n_fail <= MAX_REPORTS)
                    $display("unexpected byte %02h last %0b at cycle %0d",
                             byte_ch.out_byte, byte_ch.last, cycle_cnt);
            end else begin
                exp_b = byte_forecast.pop_front();
                if (exp_b.b !== byte_ch.out_byte || exp_b.last !== byte_ch.last) begin
                    n_fail++;
                    if (n_fail <= MAX_REPORTS)
                        $display("byte %0d: expected %02h last %0b, got %02h last %0b",
                                 n_bytes_seen, exp_b.b, exp_b.last,
                                 byte_ch.out_byte, byte_ch.last);
                end
            end
        end
    end

    // watchdog
    initial begin
        while (cycle_cnt < LIMIT_CYCLES) @(posedge i_clk);
        $display("huffman_bit_packer_test: done, errors");
        $finish;
    end

    initial begin
        int               n_real;
        int               pick;
        int               r;
        logic [REQ_W-1:0] req;
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;

        // everything known from time zero, reset held low
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = REQ_LOAD;
        req_ch.symbol    = '0;
        req_ch.code_bits = '0;
        req_ch.code_len  = '0;
        foreach (tbl_len[i]) begin
            tbl_len[i]  = '0;
            tbl_code[i] = '0;
        end
        carry_bits = '0;
        carry_cnt  = '0;

        // directed table
        // flush straight after reset: empty buffer gives two zero bytes
        add_row(REQ_FLUSH,    8'h00, 32'h0000_0000, 6'd0,  1, 2, 32'h0000_0000);
        // never loaded symbol gives nothing
        add_row(REQ_ENCODE,   8'h00, 32'h0000_0000, 6'd0,  1, 0, 32'h0);
        // over-long length saturates to a full 32 bit code
        add_row(REQ_LOAD,     8'hFF, 32'hFFFF_FFFF, 6'd63, 1, 0, 32'h0);
        add_row(REQ_ENCODE,   8'hFF, 32'h0000_0000, 6'd0,  1, 4, 32'hFFFF_FFFF);
        // zero length means no code at all
        add_row(REQ_LOAD,     8'h00, 32'hFFFF_FFFF, 6'd0,  1, 0, 32'h0);
        add_row(REQ_ENCODE,   8'h00, 32'hFFFF_FFFF, 6'd63, 1, 0, 32'h0);
        // code bits above the length are dropped
        add_row(REQ_LOAD,     8'h01, 32'hFFFF_FFFF, 6'd1,  1, 0, 32'h0);
        add_row(REQ_ENCODE,   8'h01, 32'h0000_0000, 6'd0,  0, 0, 32'h0);
        add_row(REQ_LOAD,     8'h02, 32'hABCD_EF12, 6'd3,  1, 0, 32'h0);
        add_row(REQ_ENCODE,   8'h02, 32'h0000_0000, 6'd0,  0, 0, 32'h0);
        add_row(REQ_FLUSH,    8'hFF, 32'hFFFF_FFFF, 6'd63, 0, 0, 32'h0);
        // seven pending bits plus a 32 bit code: four bytes and seven left over
        add_row(REQ_LOAD,     8'h80, 32'h0000_007F, 6'd7,  1, 0, 32'h0);
        add_row(REQ_ENCODE,   8'h80, 32'h0000_0000, 6'd0,  0, 0, 32'h0);
        add_row(REQ_ENCODE,   8'hFF, 32'h0000_0000, 6'd0,  0, 0, 32'h0);
        add_row(REQ_FLUSH,    8'h00, 32'h0000_0000, 6'd0,  0, 0, 32'h0);
        // byte-aligned codes from an empty buffer
        add_row(REQ_LOAD,     8'h55, 32'h0000_0000, 6'd32, 1, 0, 32'h0);
        add_row(REQ_LOAD,     8'hAA, 32'h0000_00AA, 6'd8,  1, 0, 32'h0);
        add_row(REQ_ENCODE,   8'hAA, 32'h0000_0000, 6'd0,  1, 1, 32'hAA00_0000);
        add_row(REQ_ENCODE,   8'h55, 32'h0000_0000, 6'd0,  1, 4, 32'h0000_0000);
        add_row(REQ_LOAD,     8'h7E, 32'h8000_0001, 6'd33, 1, 0, 32'h0);
        // reserved type dressed as a load must not touch the table
        add_row(REQ_RESERVED, 8'h01, 32'h0000_0000, 6'd5,  1, 0, 32'h0);
        add_row(REQ_ENCODE,   8'h01, 32'h0000_0000, 6'd0,  0, 0, 32'h0);
        add_row(REQ_ENCODE,   8'h7E, 32'h0000_0000, 6'd0,  0, 0, 32'h0);
        add_row(REQ_FLUSH,    8'h00, 32'h0000_0000, 6'd0,  0, 0, 32'h0);

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (stim_rows[i])
            send_req(stim_rows[i].req, stim_rows[i].sym, stim_rows[i].code,
                     stim_rows[i].len, stim_rows[i].typed, stim_rows[i].n,
                     stim_rows[i].bytes);

        // random part: mostly encodes of loaded symbols, a steady trickle of
        // (re)loads and flushes, and some reserved requests as noise
        n_real = 0;
        while (n_real < N_RANDOM_REQS) begin
            if (n_real % 40 == 0) tx_calm = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 99);
            sym  = SYM_W'($urandom_range(0, 255));
            len  = LEN_W'($urandom_range(0, 63));
            if (pick < 5) begin
                req = REQ_RESERVED;
            end else if (pick < 25) begin
                req = REQ_LOAD;
                if (alphabet.size() > 0 && $urandom_range(0, 9) < 3)
                    sym = SYM_W'(alphabet[$urandom_range(0, alphabet.size() - 1)]);
                r = $urandom_range(0, 19);
                if (r == 0)      len = '0;
                else if (r < 3)  len = LEN_W'($urandom_range(33, 63));
                else if (r < 5)  len = LEN_W'($urandom_range(13, 32));
                else             len = LEN_W'($urandom_range(1, 12));
                alphabet = {alphabet, int'(sym)};
            end else if (pick < 88) begin
                req = REQ_ENCODE;
                if ($urandom_range(0, 99) < 85)
                    sym = SYM_W'(alphabet[$urandom_range(0, alphabet.size() - 1)]);
            end else begin
                req = REQ_FLUSH;
            end
            send_req(req, sym, $urandom(), len, 0, 0, 32'h0);
            if (req != REQ_RESERVED) n_real++;
        end
        @(negedge i_clk);
        req_ch.valid = 1'b0;

        // let the last bytes drain, then let the block idle for DRAIN_CYCLES
        while (byte_forecast.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d loads, %0d encodes, %0d flushes and %0d reserved requests",
                 n_load, n_encode, n_flush, n_reserved);
        $display("%0d packed bytes compared, %0d failures", n_bytes_seen, n_fail);
        if (n_fail == 0) begin
            $display("huffman_bit_packer_test: done, clean");
        end else begin
            $display("huffman_bit_packer_test: done, errors");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/hbp_pkg.sv
rtl/core/hbp_req_if.sv
rtl/core/hbp_byte_if.sv
rtl/core/hbp_code_mem.sv
rtl/core/hbp_packer.sv
rtl/core/huffman_bit_packer.sv
tb/sv/huffman_bit_packer_test.sv
